/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the list move engine.
// Each macro clocks on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLME_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/olme_pkg.sv */
// Package of the ordered list move engine: sizes, codes, the command and
// status structs between controller and datapath, and link reset functions.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package olme_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int IW        = 6;
    localparam int DEPTH     = MAX_ITEMS + 1;
    localparam int AW        = $clog2(DEPTH);

    typedef logic [IW-1:0] t_item;
    typedef logic [AW-1:0] t_addr;
    typedef logic [1:0]    t_code;

    localparam t_code OP_INIT   = 2'd0;
    localparam t_code OP_BEFORE = 2'd1;
    localparam t_code OP_AFTER  = 2'd2;
    localparam t_code OP_READ   = 2'd3;

    localparam t_code ST_OK    = 2'd0;
    localparam t_code ST_SAME  = 2'd1;
    localparam t_code ST_RANGE = 2'd2;
    localparam t_code ST_EMPTY = 2'd3;

    localparam t_item LIST_LEN_RST = t_item'(32);

    typedef struct packed {
        logic  load;        // capture the accepted input word
        logic  init;        // lay out the list again
        logic  rd_ab;       // read the links of moved and target item
        logic  unlink;      // take the moved item out of the circle
        logic  ins1;        // point the neighbors at the moved item
        logic  ins2;        // point the moved item at its neighbors
        logic  walk_start;  // read the successor of the head
        logic  walk_first;  // take the first item of the walk
        logic  walk_step;   // advance the walk by one item
        logic  push;        // load the output register
        logic  res_item;    // the pushed word carries the current item
        t_code res_status;
    } t_cmd;

    typedef struct packed {
        t_code op;
        logic  empty;
        logic  len_zero;
        logic  same;
        logic  bad_range;
        logic  out_free;
        logic  walk_zero;
        logic  walk_last;
    } t_sts;

    // Links of an entry that has not been written since the last layout.
    function automatic t_item succ_default(input t_addr idx, input t_item n);
        t_item v;
        v = t_item'(idx);
        return (v == n) ? '0 : v + t_item'(1);
    endfunction

    function automatic t_item pred_default(input t_addr idx, input t_item n);
        t_item v;
        v = t_item'(idx);
        return (v == '0) ? n : v - t_item'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/olme_ctrl.sv */
// Controller of the list move engine: sequences init, moves and read out.
// Uses olme_pkg; drives the datapath through t_cmd and watches t_sts.
`timescale 1ns / 1ps
`default_nettype none

module olme_ctrl
    import olme_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK1  = 3'd2;
    localparam logic [2:0] S_WALK2  = 3'd3;
    localparam logic [2:0] S_UNLINK = 3'd4;
    localparam logic [2:0] S_INS1   = 3'd5;
    localparam logic [2:0] S_INS2   = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] r_state, n_state;
    t_code      r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op == OP_INIT) begin
                    o_cmd.init = 1'b1;
                    n_res      = i_sts.len_zero ? ST_EMPTY : ST_OK;
                    n_state    = S_RESULT;
                end else if (i_sts.empty) begin
                    n_res   = ST_EMPTY;
                    n_state = S_RESULT;
                end else if (i_sts.op == OP_READ) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK1;
                end else if (i_sts.same) begin
                    n_res   = ST_SAME;
                    n_state = S_RESULT;
                end else if (i_sts.bad_range) begin
                    n_res   = ST_RANGE;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.rd_ab = 1'b1;
                    n_state     = S_UNLINK;
                end
            end
            S_WALK1: begin
                if (i_sts.walk_zero) begin
                    n_res   = ST_EMPTY;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.walk_first = 1'b1;
                    n_state          = S_WALK2;
                end
            end
            S_WALK2: begin
                if (i_sts.out_free) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.res_item = 1'b1;
                    if (i_sts.walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                    end
                end
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_INS1;
            end
            S_INS1: begin
                o_cmd.ins1 = 1'b1;
                n_state    = S_INS2;
            end
            S_INS2: begin
                // The last link writes wait with the result for a free output word.
                if (i_sts.out_free) begin
                    o_cmd.ins2       = 1'b1;
                    o_cmd.push       = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.res_status = r_res;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/olme_dpath.sv */
// Datapath of the list move engine: link memories, operand and walk
// registers, the length register and the output word. Uses olme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olme_dpath
    import olme_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    input  wire          i_cfg_we,
    input  wire [IW-1:0] i_cfg_data,
    input  wire [1:0]    i_operation,
    input  wire [IW-1:0] i_moved_item,
    input  wire [IW-1:0] i_target_item,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output logic [IW-1:0] o_item_value,
    output logic [1:0]   o_status,
    output logic         o_last
);

    t_code r_op;
    t_item r_a, r_b;
    t_item r_cfg_len, r_count;
    t_item r_k, r_cur;
    t_item r_pins, r_sins;

    // Link tables; an entry whose valid bit is clear reads as the layout value.
    t_item              r_succ_mem [DEPTH];
    t_item              r_pred_mem [DEPTH];
    logic [DEPTH-1:0]   r_succ_vld, r_pred_vld;

    t_item r_sa_q, r_pa_q, r_sb_q, r_pb_q;
    logic  r_sa_v, r_pa_v, r_sb_v, r_pb_v;
    t_addr r_ra_addr, r_rb_addr;

    t_item sa_data, pa_data, sb_data, pb_data;
    logic  rd_a_en;
    t_addr rd_a_addr;
    logic  succ_we, pred_we;
    t_addr succ_waddr, pred_waddr;
    t_item succ_wdata, pred_wdata;
    t_item len_clamped;
    logic  out_free, walk_last;

    assign sa_data = r_sa_v ? r_sa_q : succ_default(r_ra_addr, r_count);
    assign pa_data = r_pa_v ? r_pa_q : pred_default(r_ra_addr, r_count);
    assign sb_data = r_sb_v ? r_sb_q : succ_default(r_rb_addr, r_count);
    assign pb_data = r_pb_v ? r_pb_q : pred_default(r_rb_addr, r_count);

    assign len_clamped = (r_cfg_len > t_item'(MAX_ITEMS)) ? t_item'(MAX_ITEMS) : r_cfg_len;
    assign out_free    = !o_out_valid || !i_out_stall;
    assign walk_last   = (sa_data == '0) || ((r_k + t_item'(1)) == r_count);

    always_comb begin
        o_sts           = '0;
        o_sts.op        = r_op;
        o_sts.empty     = (r_count == '0);
        o_sts.len_zero  = (r_cfg_len == '0);
        o_sts.same      = (r_a == r_b);
        o_sts.bad_range = (r_a == '0) || (r_b == '0) || (r_a > r_count) || (r_b > r_count);
        o_sts.out_free  = out_free;
        o_sts.walk_zero = (sa_data == '0);
        o_sts.walk_last = walk_last;
    end

    // Read port A serves the moved item and the walk; port B the target.
    assign rd_a_en   = i_cmd.rd_ab | i_cmd.walk_start | i_cmd.walk_first | i_cmd.walk_step;
    always_comb begin
        if (i_cmd.rd_ab) begin
            rd_a_addr = t_addr'(r_a);
        end else if (i_cmd.walk_start) begin
            rd_a_addr = '0;
        end else begin
            rd_a_addr = t_addr'(sa_data);
        end
    end

    // Unlink: succ[p] = s, pred[s] = p. Insert: neighbors first, then the item.
    always_comb begin
        succ_we    = i_cmd.unlink | i_cmd.ins1 | i_cmd.ins2;
        pred_we    = succ_we;
        succ_waddr = t_addr'(r_a);
        succ_wdata = r_sins;
        pred_waddr = t_addr'(r_a);
        pred_wdata = r_pins;
        if (i_cmd.unlink) begin
            succ_waddr = t_addr'(pa_data);
            succ_wdata = sa_data;
            pred_waddr = t_addr'(sa_data);
            pred_wdata = pa_data;
        end else if (i_cmd.ins1) begin
            succ_waddr = t_addr'(r_pins);
            succ_wdata = r_a;
            pred_waddr = t_addr'(r_sins);
            pred_wdata = r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (succ_we) begin
            r_succ_mem[succ_waddr] <= succ_wdata;
        end
        if (pred_we) begin
            r_pred_mem[pred_waddr] <= pred_wdata;
        end
        if (rd_a_en) begin
            r_sa_q    <= r_succ_mem[rd_a_addr];
            r_pa_q    <= r_pred_mem[rd_a_addr];
            r_sa_v    <= r_succ_vld[rd_a_addr];
            r_pa_v    <= r_pred_vld[rd_a_addr];
            r_ra_addr <= rd_a_addr;
        end
        if (i_cmd.rd_ab) begin
            r_sb_q    <= r_succ_mem[t_addr'(r_b)];
            r_pb_q    <= r_pred_mem[t_addr'(r_b)];
            r_sb_v    <= r_succ_vld[t_addr'(r_b)];
            r_pb_v    <= r_pred_vld[t_addr'(r_b)];
            r_rb_addr <= t_addr'(r_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_succ_vld <= '0;
            r_pred_vld <= '0;
        end else begin
            if (succ_we) begin
                r_succ_vld[succ_waddr] <= 1'b1;
            end
            if (pred_we) begin
                r_pred_vld[pred_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= LIST_LEN_RST;
            r_count   <= LIST_LEN_RST;
        end else begin
            if (i_cfg_we) begin
                r_cfg_len <= i_cfg_data;
            end
            if (i_cmd.init) begin
                r_count <= len_clamped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_a  <= i_moved_item;
            r_b  <= i_target_item;
        end
        if (i_cmd.walk_first) begin
            r_cur <= sa_data;
            r_k   <= '0;
        end else if (i_cmd.walk_step) begin
            r_cur <= sa_data;
            r_k   <= r_k + t_item'(1);
        end
        // The target's links as they stand once the moved item is out.
        if (i_cmd.unlink) begin
            if (r_op == OP_BEFORE) begin
                r_pins <= (r_b == sa_data) ? pa_data : pb_data;
                r_sins <= r_b;
            end else begin
                r_pins <= r_b;
                r_sins <= (r_b == pa_data) ? sa_data : sb_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_item_value <= i_cmd.res_item ? r_cur : '0;
            o_status     <= i_cmd.res_item ? ST_OK : i_cmd.res_status;
            o_last       <= i_cmd.res_item ? walk_last : 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/ordered_list_move_engine_core.sv */
// Ordered list move engine. Items 1..list_length form a circular order held
// in successor and predecessor link tables (33 entries each, one write and two
// registered reads per cycle). One input word is worked at a time: a move
// makes three rounds of link writes on the single write port of each table,
// the last together with its status word; init and every rejected command go
// from decode to their status word; a read out walks the list, following one
// successor link per cycle while the output is not stalled. list_length takes
// effect at the next init; after reset the list holds 32 items in ascending order.
// Depends on olme_pkg, olme_ctrl and olme_dpath.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_move_engine_core
    import olme_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [IW-1:0] i_cfg_data,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire [1:0]    i_operation,
    input  wire [IW-1:0] i_moved_item,
    input  wire [IW-1:0] i_target_item,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output logic [IW-1:0] o_item_value,
    output logic [1:0]   o_status,
    output logic         o_last
);

    t_cmd cmd;
    t_sts sts;

    olme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    olme_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_moved_item  (i_moved_item),
        .i_target_item (i_target_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_item_value  (o_item_value),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* rtl/olme_checker.sv */
// Port-level checker of the list move engine, bound to the top level.
// Uses olme_pkg and the macros of assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module olme_checker
    import olme_pkg::*;
(
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_in_valid,
    input wire          o_in_stall,
    input wire          o_out_valid,
    input wire          i_out_stall,
    input wire [IW-1:0] o_item_value,
    input wire [1:0]    o_status,
    input wire          o_last
);

    // One word at a time: a new word is held off right after one is taken.
    `OLME_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall,
        "input taken while busy")
    `OLME_ASSERT_IMP(a_error_is_last, o_out_valid && o_status != ST_OK, o_last,
        "error word not last")
    `OLME_ASSERT_IMP(a_error_no_item, o_out_valid && o_status != ST_OK,
        o_item_value == '0, "error word with item")
    `OLME_ASSERT_IMP(a_walk_busy, o_out_valid && !o_last, o_in_stall,
        "input open during read out")
    `OLME_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_item_value) && $stable(o_status) && $stable(o_last),
        "stalled output word changed")

endmodule

bind ordered_list_move_engine_core olme_checker u_olme_checker (.*);

`default_nettype wire

/* tb/tb_ordered_list_move_engine_core.sv */
// Self-checking testbench for ordered_list_move_engine_core: a scoreboard class keeps
// its own copy of the link tables and predicts every status and read-out word.
// Depends on olme_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_ordered_list_move_engine_core;
    import olme_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_GUARD  = 40;

    typedef struct packed {
        t_item value;
        t_code status;
        logic  last;
    } t_order_word;

    // Keeps the expected circular order and the queue of words still to come.
    class t_list_order_board;
        t_item       succ_link[0:MAX_ITEMS];
        t_item       pred_link[0:MAX_ITEMS];
        int unsigned item_count;
        t_item       length_reg;
        t_order_word pending_words[$];
        int unsigned mismatches;
        int unsigned words_checked;

        function new();
            length_reg    = LIST_LEN_RST;
            mismatches    = 0;
            words_checked = 0;
            lay_out_order();
        endfunction

        function void write_length(t_item data);
            length_reg = data;
        endfunction

        // Indexes past the table fall back to the head sentinel.
        function int unsigned clamp_slot(int unsigned x);
            return (x <= MAX_ITEMS) ? x : 0;
        endfunction

        function void lay_out_order();
            int unsigned n;
            n = (length_reg > MAX_ITEMS) ? MAX_ITEMS : length_reg;
            for (int i = 0; i <= MAX_ITEMS; i++) begin
                succ_link[i] = '0;
                pred_link[i] = '0;
            end
            for (int i = 0; i < n; i++) begin
                succ_link[i]   = t_item'(i + 1);
                pred_link[i+1] = t_item'(i);
            end
            succ_link[n] = '0;
            pred_link[0] = t_item'(n);
            item_count   = n;
        endfunction

        function void push_word(t_item value, t_code status, logic last);
            t_order_word w;
            w.value  = value;
            w.status = status;
            w.last   = last;
            pending_words.push_back(w);
        endfunction

        function void note_command(t_code op, t_item a, t_item b);
            int unsigned p, s, cur, k;
            t_order_word walk[$];
            t_order_word w;
            if (op == OP_INIT) begin
                lay_out_order();
                push_word('0, (item_count == 0) ? ST_EMPTY : ST_OK, 1'b1);
                return;
            end
            if (item_count == 0) begin
                push_word('0, ST_EMPTY, 1'b1);
                return;
            end
            if (op == OP_READ) begin
                k   = 0;
                cur = clamp_slot(succ_link[0]);
                while (cur != 0 && k < MAX_ITEMS && k < item_count) begin
                    w.value  = t_item'(cur);
                    w.status = ST_OK;
                    w.last   = 1'b0;
                    walk.push_back(w);
                    k++;
                    cur = clamp_slot(succ_link[cur]);
                end
                if (k == 0) begin
                    push_word('0, ST_EMPTY, 1'b1);
                    return;
                end
                walk[k-1].last = 1'b1;
                foreach (walk[i]) pending_words.push_back(walk[i]);
                return;
            end
            // The same-item check comes ahead of the range check.
            if (a == b) begin
                push_word('0, ST_SAME, 1'b1);
                return;
            end
            if (a == 0 || b == 0 || a > item_count || b > item_count) begin
                push_word('0, ST_RANGE, 1'b1);
                return;
            end
            p = clamp_slot(pred_link[a]);
            s = clamp_slot(succ_link[a]);
            succ_link[p] = t_item'(s);
            pred_link[s] = t_item'(p);
            // Neighbors of the target are taken after the moved item is out.
            if (op == OP_BEFORE) begin
                p = clamp_slot(pred_link[b]);
                s = b;
            end else begin
                p = b;
                s = clamp_slot(succ_link[b]);
            end
            succ_link[p] = a;
            pred_link[a] = t_item'(p);
            pred_link[s] = a;
            succ_link[a] = t_item'(s);
            push_word('0, ST_OK, 1'b1);
        endfunction

        function void check_word(t_item value, t_code status, logic last);
            t_order_word want;
            words_checked++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, got value %0d status %0d last %0d",
                         $time, value, status, last);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            if (value !== want.value) begin
                $display("%0t: item_value mismatch: expected %0d, got %0d",
                         $time, want.value, value);
                mismatches++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, status);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch: expected %0d, got %0d",
                         $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [IW-1:0] i_cfg_data = '0;
    logic         i_in_valid = 1'b0;
    logic         o_in_stall;
    logic [1:0]   i_operation = OP_INIT;
    logic [IW-1:0] i_moved_item = '0;
    logic [IW-1:0] i_target_item = '0;
    logic         o_out_valid;
    logic         i_out_stall = 1'b0;
    logic [IW-1:0] o_item_value;
    logic [1:0]   o_status;
    logic         o_last;

    t_list_order_board board;
    int unsigned cycle_count = 0;
    int unsigned commands_sent = 0;
    int unsigned reads_sent = 0;
    int unsigned moves_sent = 0;
    int unsigned lengths_used = 0;
    bit          calm_input = 1'b0;

    ordered_list_move_engine_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_moved_item (i_moved_item),
        .i_target_item(i_target_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_item_value (o_item_value),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, board.pending_words.size());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure, with long stretches of no stalling now and then.
    always begin : out_stall_gen
        int hold;
        @(posedge i_clk);
        if ($urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b0;
            hold = $urandom_range(40, 150);
        end else begin
            i_out_stall <= 1'($urandom_range(0, 1));
            hold = pick_gap();
        end
        repeat (hold) @(posedge i_clk);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_word(o_item_value, o_status, o_last);
    end

    // Valid is left high after acceptance so that back-to-back words need
    // only one assignment in a time step.
    task automatic send_command(input t_code op, input t_item a, input t_item b);
        int gap;
        gap = calm_input ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_moved_item  <= a;
        i_target_item <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_command(op, a, b);
        commands_sent++;
        if (op == OP_READ) reads_sent++;
        if (op == OP_BEFORE || op == OP_AFTER) moves_sent++;
    endtask

    task automatic settle_and_set_length(input t_item len);
        i_in_valid <= 1'b0;
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_length(len);
        lengths_used++;
    endtask

    task automatic random_command();
        int unsigned n;
        int r;
        t_code op;
        n  = board.item_count;
        r  = $urandom_range(0, 99);
        op = $urandom_range(0, 1) ? OP_AFTER : OP_BEFORE;
        if (r < 8) begin
            send_command(OP_READ, t_item'($urandom_range(0, 63)), t_item'($urandom_range(0, 63)));
        end else if (r < 80 && n > 0) begin
            send_command(op, t_item'($urandom_range(1, n)), t_item'($urandom_range(1, n)));
        end else if (r < 88) begin
            t_item same;
            same = t_item'($urandom_range(0, 63));
            send_command(op, same, same);
        end else if (r < 97) begin
            send_command(op, t_item'($urandom_range(0, 63)), t_item'($urandom_range(0, 63)));
        end else begin
            send_command(OP_INIT, t_item'($urandom_range(0, 63)), t_item'($urandom_range(0, 63)));
        end
    endtask

    initial begin
        int unsigned lengths[9];
        int unsigned count;
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default layout of 32 items: read outs, moves at both ends, rejected moves, an init.
        send_command(OP_READ,   6'd0,  6'd0);
        send_command(OP_BEFORE, 6'd32, 6'd1);
        send_command(OP_AFTER,  6'd1,  6'd32);
        send_command(OP_BEFORE, 6'd5,  6'd5);
        send_command(OP_AFTER,  6'd0,  6'd3);
        send_command(OP_BEFORE, 6'd4,  6'd33);
        send_command(OP_AFTER,  6'd63, 6'd63);
        send_command(OP_BEFORE, 6'd63, 6'd1);
        send_command(OP_AFTER,  6'd7,  6'd0);
        send_command(OP_READ,   6'd63, 6'd63);
        send_command(OP_INIT,   6'd63, 6'd63);
        send_command(OP_READ,   6'd0,  6'd0);

        // Empty list: every command reports empty, even a same-item move.
        settle_and_set_length(6'd0);
        send_command(OP_INIT,   6'd0,  6'd0);
        send_command(OP_BEFORE, 6'd1,  6'd2);
        send_command(OP_READ,   6'd0,  6'd0);
        send_command(OP_AFTER,  6'd3,  6'd3);

        // A length above the table size is clamped.
        settle_and_set_length(6'd63);
        send_command(OP_INIT,   6'd0,  6'd0);
        send_command(OP_READ,   6'd0,  6'd0);

        settle_and_set_length(6'd1);
        send_command(OP_INIT,   6'd0,  6'd0);
        send_command(OP_BEFORE, 6'd1,  6'd1);
        send_command(OP_AFTER,  6'd1,  6'd2);
        send_command(OP_READ,   6'd0,  6'd0);

        lengths = '{32, 5, 1, 0, 48, 17, 63, 2, 0};
        lengths[8] = $urandom_range(0, 63);
        foreach (lengths[p]) begin
            settle_and_set_length(t_item'(lengths[p]));
            calm_input = ($urandom_range(0, 3) == 0);
            send_command(OP_INIT, t_item'($urandom_range(0, 63)), t_item'($urandom_range(0, 63)));
            count = (board.item_count == 0) ? 8 : 34;
            repeat (count) random_command();
        end

        i_in_valid <= 1'b0;
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);

        $display("Sent %0d commands (%0d moves, %0d read-outs) over %0d list lengths;",
                 commands_sent, moves_sent, reads_sent, lengths_used);
        $display("checked %0d result words, %0d field mismatches.",
                 board.words_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/olme_pkg.sv
rtl/olme_ctrl.sv
rtl/olme_dpath.sv
rtl/ordered_list_move_engine_core.sv
rtl/olme_checker.sv
tb/tb_ordered_list_move_engine_core.sv
